FILE: src/ard_pkg.sv
package ard_pkg;

  localparam int HeaderBytes     = 12;
  localparam int NameBufferBytes = 80;

  localparam logic [3:0] SyncEnd = 4'd3;
  localparam logic [3:0] NameEnd = 4'd7;
  localparam logic [3:0] HdrEnd  = 4'(HeaderBytes - 1);

  typedef enum logic {
    OP_START = 1'b0,
    OP_DATA  = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEADER,
    PH_NAME,
    PH_PAYLOAD,
    PH_DRAIN
  } phase_e;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_NAME    = 2'd1,
    KIND_PAYLOAD = 2'd2,
    KIND_ERROR   = 2'd3
  } record_kind_e;

  typedef enum logic [1:0] {
    ERR_SYNC = 2'd0,
    ERR_NAME = 2'd1,
    ERR_FIT  = 2'd2
  } error_code_e;

  typedef struct packed {
    logic        operation;
    logic [31:0] buffer_length;
    logic        is_aggregate;
    logic [7:0]  data_byte;
  } req_t;

  typedef struct packed {
    record_kind_e record_kind;
    logic [7:0]   byte_value;
    logic [6:0]   name_len;
    logic [31:0]  data_len;
    error_code_e  error_code;
    logic         last_of_record;
    logic         passthrough;
  } res_t;

endpackage

FILE: src/ard_req_if.sv
interface ard_req_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [31:0] buffer_length;
  logic        is_aggregate;
  logic [7:0]  data_byte;

  modport source (output valid, operation, buffer_length, is_aggregate, data_byte,
                  input ready);
  modport sink (input valid, operation, buffer_length, is_aggregate, data_byte,
                output ready);
endinterface

FILE: src/ard_res_if.sv
interface ard_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  record_kind;
  logic [7:0]  byte_value;
  logic [6:0]  name_len;
  logic [31:0] data_len;
  logic [1:0]  error_code;
  logic        last_of_record;
  logic        passthrough;

  modport source (output valid, record_kind, byte_value, name_len, data_len,
                  error_code, last_of_record, passthrough,
                  input ready);
  modport sink (input valid, record_kind, byte_value, name_len, data_len,
                error_code, last_of_record, passthrough,
                output ready);
endinterface

FILE: src/ard_parser.sv
module ard_parser #(
  parameter int NAME_BUFFER_BYTES = ard_pkg::NameBufferBytes
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  ard_pkg::req_t req_i,
  input  logic [31:0]   sync_word_i,
  output ard_pkg::res_t res_o,
  output logic          res_valid_o
);
  import ard_pkg::*;

  localparam int          NameW   = $clog2(NAME_BUFFER_BYTES);
  localparam logic [31:0] NameMax = 32'(NAME_BUFFER_BYTES - 1);

  phase_e             phase_q, phase_d;
  logic [31:0]        br_q, br_d;
  logic [3:0]         cnt_q, cnt_d;
  logic [31:0]        word_q, word_d;
  logic               sync_bad_q, sync_bad_d;
  logic               name_bad_q, name_bad_d;
  logic [NameW-1:0]   nm_q, nm_d;
  logic [NameW-1:0]   name_left_q, name_left_d;
  logic [31:0]        payload_q, payload_d;
  logic               agg_q, agg_d;

  logic [31:0]        br_dec;
  logic [31:0]        low;
  logic [NameW-1:0]   nl_new;
  logic [31:0]        pl_new;
  logic               fit_bad;

  function automatic phase_e after_rec(input logic agg, input logic [31:0] br);
    phase_e ph;
    if (agg && br > 32'(HeaderBytes)) begin
      ph = PH_HEADER;
    end else if (br != '0) begin
      ph = PH_DRAIN;
    end else begin
      ph = PH_IDLE;
    end
    return ph;
  endfunction

  always_comb begin
    phase_d     = phase_q;
    br_d        = br_q;
    cnt_d       = cnt_q;
    word_d      = word_q;
    sync_bad_d  = sync_bad_q;
    name_bad_d  = name_bad_q;
    nm_d        = nm_q;
    name_left_d = name_left_q;
    payload_d   = payload_q;
    agg_d       = agg_q;
    res_o       = '0;
    res_valid_o = 1'b0;

    br_dec  = br_q - 32'd1;
    low     = (cnt_q[1:0] == 2'd0) ? '0 : word_q;
    low[{cnt_q[1:0], 3'b000} +: 8] = req_i.data_byte;
    nl_new  = (name_left_q != '0) ? name_left_q - NameW'(1) : '0;
    pl_new  = (payload_q != '0) ? payload_q - 32'd1 : '0;
    fit_bad = ({{(33 - NameW){1'b0}}, nm_q} + {1'b0, low}) > {1'b0, br_dec};

    if (accept_i) begin
      if (req_i.operation == OP_START) begin
        agg_d       = req_i.is_aggregate;
        br_d        = req_i.buffer_length;
        cnt_d       = '0;
        name_left_d = '0;
        payload_d   = '0;
        if (!req_i.is_aggregate) begin
          payload_d               = req_i.buffer_length;
          phase_d                 = (req_i.buffer_length != '0) ? PH_PAYLOAD : PH_IDLE;
          res_valid_o             = 1'b1;
          res_o.record_kind       = KIND_HEADER;
          res_o.data_len          = req_i.buffer_length;
          res_o.last_of_record    = (req_i.buffer_length == '0);
          res_o.passthrough       = 1'b1;
        end else begin
          phase_d = after_rec(1'b1, req_i.buffer_length);
        end
      end else if (phase_q != PH_IDLE && br_q != '0) begin
        br_d = br_dec;
        case (phase_q)
          PH_HEADER: begin
            word_d = low;
            cnt_d  = cnt_q + 4'd1;
            if (cnt_q == SyncEnd) begin
              sync_bad_d = (low != sync_word_i);
            end
            if (cnt_q == NameEnd) begin
              name_bad_d = (low > NameMax);
              nm_d       = low[NameW-1:0];
            end
            if (cnt_q == HdrEnd) begin
              cnt_d       = '0;
              res_valid_o = 1'b1;
              if (sync_bad_q || name_bad_q || fit_bad) begin
                phase_d              = (br_dec != '0) ? PH_DRAIN : PH_IDLE;
                res_o.record_kind    = KIND_ERROR;
                res_o.last_of_record = 1'b1;
                if (sync_bad_q) begin
                  res_o.error_code = ERR_SYNC;
                end else if (name_bad_q) begin
                  res_o.error_code = ERR_NAME;
                end else begin
                  res_o.error_code = ERR_FIT;
                end
              end else begin
                name_left_d = nm_q;
                payload_d   = low;
                if (nm_q != '0) begin
                  phase_d = PH_NAME;
                end else if (low != '0) begin
                  phase_d = PH_PAYLOAD;
                end else begin
                  phase_d = after_rec(agg_q, br_dec);
                end
                res_o.record_kind    = KIND_HEADER;
                res_o.name_len       = 7'(nm_q);
                res_o.data_len       = low;
                res_o.last_of_record = (nm_q == '0) && (low == '0);
              end
            end
          end
          PH_NAME: begin
            name_left_d = nl_new;
            if (nl_new == '0) begin
              phase_d = (payload_q != '0) ? PH_PAYLOAD : after_rec(agg_q, br_dec);
            end
            res_valid_o          = 1'b1;
            res_o.record_kind    = KIND_NAME;
            res_o.byte_value     = req_i.data_byte;
            res_o.last_of_record = (nl_new == '0) && (payload_q == '0);
          end
          PH_PAYLOAD: begin
            payload_d = pl_new;
            if (pl_new == '0) begin
              phase_d = after_rec(agg_q, br_dec);
            end
            res_valid_o          = 1'b1;
            res_o.record_kind    = KIND_PAYLOAD;
            res_o.byte_value     = req_i.data_byte;
            res_o.last_of_record = (pl_new == '0);
            res_o.passthrough    = !agg_q;
          end
          default: begin
            if (br_dec == '0) begin
              phase_d = PH_IDLE;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      br_q        <= '0;
      cnt_q       <= '0;
      name_left_q <= '0;
      payload_q   <= '0;
      agg_q       <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      br_q        <= br_d;
      cnt_q       <= cnt_d;
      name_left_q <= name_left_d;
      payload_q   <= payload_d;
      agg_q       <= agg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q     <= word_d;
    sync_bad_q <= sync_bad_d;
    name_bad_q <= name_bad_d;
    nm_q       <= nm_d;
  end

  a_open_has_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != PH_IDLE |-> br_q != '0)
    else $error("open buffer with no bytes left");

  a_name_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_NAME |-> name_left_q != '0)
    else $error("name phase with empty name count");

  a_payload_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAYLOAD |-> payload_q != '0)
    else $error("payload phase with empty payload count");

  a_record_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_NAME || phase_q == PH_PAYLOAD) |->
      ({{(33 - NameW){1'b0}}, name_left_q} + {1'b0, payload_q}) <= {1'b0, br_q})
    else $error("record overruns buffer");

  a_header_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_HEADER |-> cnt_q <= HdrEnd)
    else $error("header byte count out of range");

endmodule

FILE: src/aggregate_record_deframer.sv
// Aggregate record deframer. A start request gives the buffer length and the
// aggregate flag; the buffer bytes then follow one per request. Aggregated
// records open with a 12-byte little-endian header (sync word, name length,
// data length) which is checked against the sync_word register, the name
// limit and the bytes left; a header or error result is then produced, and
// each name and payload byte comes out tagged. After the first error the
// rest of the buffer is dropped, as is a tail of 12 bytes or fewer. A plain
// buffer comes out as one passthrough record. Each request's result is
// formed combinationally from the parser state and registered in the output
// register, so one request is accepted per clock; req ready drops only while
// a result sits in the output register and the result sink is not ready.
module aggregate_record_deframer #(
  parameter int NAME_BUFFER_BYTES = ard_pkg::NameBufferBytes
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  ard_req_if.sink     req_i,
  ard_res_if.source   res_o
);
  import ard_pkg::*;

  logic [31:0] sync_q;
  logic        out_valid_q, out_valid_d;
  res_t        out_q;
  res_t        res;
  logic        res_valid;
  logic        accept;
  req_t        req;

  assign req.operation     = req_i.operation;
  assign req.buffer_length = req_i.buffer_length;
  assign req.is_aggregate  = req_i.is_aggregate;
  assign req.data_byte     = req_i.data_byte;

  assign req_i.ready = !out_valid_q || res_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  ard_parser #(
    .NAME_BUFFER_BYTES(NAME_BUFFER_BYTES)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .req_i      (req),
    .sync_word_i(sync_q),
    .res_o      (res),
    .res_valid_o(res_valid)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (accept && res_valid) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        sync_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && res_valid) begin
      out_q <= res;
    end
  end

  assign res_o.valid          = out_valid_q;
  assign res_o.record_kind    = out_q.record_kind;
  assign res_o.byte_value     = out_q.byte_value;
  assign res_o.name_len       = out_q.name_len;
  assign res_o.data_len       = out_q.data_len;
  assign res_o.error_code     = out_q.error_code;
  assign res_o.last_of_record = out_q.last_of_record;
  assign res_o.passthrough    = out_q.passthrough;

endmodule
